// ----- rtl/core/msbee_pkg.sv -----
// Shared types and constants for the MSB message embed/extract block.
`default_nettype none

package msbee_pkg;

	localparam int unsigned LCG_W = 31;

	localparam logic [LCG_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [14:0]      LCG_MUL = 15'd16807;

	localparam logic [7:0] END_CODE = 8'd4;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam logic REG_KEY_SEED = 1'b0;
	localparam logic REG_MODE     = 1'b1;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic             restart;
		logic [LCG_W-1:0] seed;
		logic             advance;
	} lcg_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/msb_message_embed_extract_top.sv -----
// Top level of the MSB message embed/extract block.
// Usage:
//   s_axis carries requests: tuser = req_type (0 load a message byte, 1 process a pixel),
//   tlast = msg_last, tdata = msg_byte [7:0], pixel_in [15:8].
//   m_axis carries one result per pixel request, none per load:
//   tdata = pixel_out [7:0], byte_out [15:8]; tuser = byte_valid [0], need_byte [1];
//   tlast = end_found.
//   cfg_we/cfg_addr/cfg_wdata write key_seed (index 0) or mode (index 1); either write
//   reloads the keystream from the seed and clears the embed/extract progress.
//   Write configuration only while no transaction is in flight.
// Timing:
//   An accepted transaction sits in the input stage, then is processed combinationally
//   into the output register, loaded when the input stage advances. One transaction
//   per cycle is sustained while m_axis_tready is high; the keystream step (one 31x15
//   constant multiply and a Mersenne fold) is the longest path of the state loop.
// Reset: arst_n clears both stages, key_seed = 1, mode = embed.
// Stall: with m_axis_tready low the output register holds; the input stage holds one
//   more transaction, then s_axis_tready drops. Loads still drain past a full output.
`default_nettype none

module msb_message_embed_extract_top
	import msbee_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // msg_byte [7:0], pixel_in [15:8]
	input  wire logic        s_axis_tuser,   // req_type
	input  wire logic        s_axis_tlast,   // msg_last

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // pixel_out [7:0], byte_out [15:8]
	output logic [1:0]       m_axis_tuser,   // byte_valid [0], need_byte [1]
	output logic             m_axis_tlast,   // end_found

	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [30:0] cfg_wdata
);

	// input stage
	logic       valid_s1;
	logic       req_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic [7:0] pix_s1;

	// output register
	logic       out_valid_q;
	logic [7:0] pixel_out_q;
	logic [7:0] byte_out_q;
	logic       byte_valid_q;
	logic       end_found_q;
	logic       need_byte_q;

	// configuration and session state
	logic [LCG_W-1:0] key_seed_q;
	logic             mode_q;
	logic [7:0]       bit_shift_q;
	logic [3:0]       bits_left_q;
	logic             final_loaded_q;
	logic             finished_q;

	logic             advance;
	logic             restart;
	lcg_ctrl_t        lcg_ctrl;
	logic [7:0]       key_byte;
	logic [LCG_W-1:0] lcg_value;

	logic [7:0] bit_shift_d;
	logic [3:0] bits_left_d;
	logic       final_loaded_d;
	logic       finished_d;
	logic       key_step;
	logic [7:0] pixel_out_d;
	logic [7:0] byte_out_d;
	logic       byte_valid_d;
	logic       end_found_d;
	logic       need_byte_d;
	logic [7:0] shift_in;
	logic [3:0] count_in;

	assign advance       = valid_s1 && (req_s1 == REQ_LOAD || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign restart       = cfg_we;

	always_comb begin
		lcg_ctrl.restart = restart;
		lcg_ctrl.seed    = (cfg_addr == REG_KEY_SEED) ? cfg_wdata : key_seed_q;
		lcg_ctrl.advance = advance && key_step;
	end

	msbee_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (lcg_ctrl),
		.key_byte  (key_byte),
		.lcg_value (lcg_value)
	);

	always_comb begin
		bit_shift_d    = bit_shift_q;
		bits_left_d    = bits_left_q;
		final_loaded_d = final_loaded_q;
		finished_d     = finished_q;
		key_step       = 1'b0;
		pixel_out_d    = pix_s1;
		byte_out_d     = 8'd0;
		byte_valid_d   = 1'b0;
		end_found_d    = 1'b0;
		need_byte_d    = 1'b0;
		shift_in       = {bit_shift_q[6:0], pix_s1[7]};
		count_in       = bits_left_q + 4'd1;

		if (req_s1 == REQ_LOAD) begin
			if (mode_q == MODE_EMBED && bits_left_q == 4'd0 && !final_loaded_q) begin
				key_step       = 1'b1;
				bit_shift_d    = byte_s1 ^ key_byte;
				bits_left_d    = BITS_PER_BYTE;
				final_loaded_d = last_s1;
			end
		end else if (mode_q == MODE_EMBED) begin
			if (bits_left_q != 4'd0) begin
				pixel_out_d = {bit_shift_q[7], pix_s1[6:0]};
				bit_shift_d = {bit_shift_q[6:0], 1'b0};
				bits_left_d = bits_left_q - 4'd1;
				if (bits_left_d == 4'd0 && final_loaded_q) begin
					finished_d = 1'b1;
				end
			end
			need_byte_d = (bits_left_d == 4'd0) && !final_loaded_q;
		end else if (!finished_q) begin
			bit_shift_d = shift_in;
			bits_left_d = count_in;
			if (count_in >= BITS_PER_BYTE) begin
				key_step     = 1'b1;
				byte_out_d   = shift_in ^ key_byte;
				byte_valid_d = 1'b1;
				end_found_d  = (byte_out_d == END_CODE);
				if (end_found_d) begin
					finished_d = 1'b1;
				end
				bits_left_d = 4'd0;
				bit_shift_d = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
			pix_s1  <= s_axis_tdata[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_seed_q     <= LCG_W'(1);
			mode_q         <= MODE_EMBED;
			bit_shift_q    <= 8'd0;
			bits_left_q    <= 4'd0;
			final_loaded_q <= 1'b0;
			finished_q     <= 1'b0;
		end else if (restart) begin
			if (cfg_addr == REG_KEY_SEED) begin
				key_seed_q <= cfg_wdata;
			end else begin
				mode_q <= cfg_wdata[0];
			end
			bit_shift_q    <= 8'd0;
			bits_left_q    <= 4'd0;
			final_loaded_q <= 1'b0;
			finished_q     <= 1'b0;
		end else if (advance) begin
			bit_shift_q    <= bit_shift_d;
			bits_left_q    <= bits_left_d;
			final_loaded_q <= final_loaded_d;
			finished_q     <= finished_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && req_s1 == REQ_PIXEL) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_s1 == REQ_PIXEL) begin
			pixel_out_q  <= pixel_out_d;
			byte_out_q   <= byte_out_d;
			byte_valid_q <= byte_valid_d;
			end_found_q  <= end_found_d;
			need_byte_q  <= need_byte_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {byte_out_q, pixel_out_q};
	assign m_axis_tuser  = {need_byte_q, byte_valid_q};
	assign m_axis_tlast  = end_found_q;

	a_lcg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_value != '0 && lcg_value != LCG_MOD)
		else $error("keystream state left the field");

	a_end_implies_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0] && m_axis_tdata[15:8] == END_CODE)
		else $error("end_found without terminator byte");

	a_mode_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("byte_valid and need_byte together");

	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= BITS_PER_BYTE)
		else $error("bit counter out of range");

endmodule

`default_nettype wire

// ----- rtl/core/msbee_lcg.sv -----
// Lehmer keystream generator: x' = 16807 * x mod (2^31 - 1), one step per advance.
`default_nettype none

module msbee_lcg
	import msbee_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lcg_ctrl_t       ctrl,
	output logic [7:0]           key_byte,
	output logic [LCG_W-1:0]     lcg_value
);

	logic [LCG_W-1:0] lcg_q;
	logic [LCG_W-1:0] seed_mapped;
	logic [LCG_W-1:0] lcg_next;
	logic [45:0]      prod;
	logic [31:0]      fold;

	// zero and the modulus itself both map to one
	always_comb begin
		if (ctrl.seed == '0 || ctrl.seed == LCG_MOD) begin
			seed_mapped = LCG_W'(1);
		end else begin
			seed_mapped = ctrl.seed;
		end
	end

	always_comb begin
		prod = 46'(lcg_q) * 46'(LCG_MUL);
		fold = {1'b0, prod[30:0]} + {17'd0, prod[45:31]};
		if (fold >= {1'b0, LCG_MOD}) begin
			lcg_next = LCG_W'(fold - {1'b0, LCG_MOD});
		end else begin
			lcg_next = fold[LCG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= LCG_W'(1);
		end else if (ctrl.restart) begin
			lcg_q <= seed_mapped;
		end else if (ctrl.advance) begin
			lcg_q <= lcg_next;
		end
	end

	assign key_byte  = lcg_next[7:0];
	assign lcg_value = lcg_q;

endmodule

`default_nettype wire
